### sv/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants of the byte pattern search core.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int PATTERN_MAX_DEF = 32;
  localparam int OFFSET_BITS_DEF = 16;

  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int IN_DATA_W = 16;

  localparam logic [2:0] REG_PATTERN_LENGTH  = 3'd0;
  localparam logic [2:0] REG_CASE_FOLD       = 3'd1;
  localparam logic [2:0] REG_RELATIVE_MODE   = 3'd2;
  localparam logic [2:0] REG_WILDCARD_ENABLE = 3'd3;
  localparam logic [2:0] REG_WILDCARD_CHAR   = 3'd4;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_STREAM = 1'b1;

  typedef struct packed {
    logic [5:0] pattern_length;
    logic       case_fold;
    logic       relative_mode;
    logic       wildcard_enable;
    logic [7:0] wildcard_char;
  } bps_cfg_t;

  typedef struct packed {
    logic       shift;
    logic       clear;
    logic       rotate;
    logic       case_fold;
    logic       relative_mode;
    logic       wildcard_enable;
    logic [7:0] wildcard_char;
    logic [7:0] load_value;
  } bps_ctl_t;

endpackage

### sv/byte_pattern_search_wildcard_core.sv
// ----------------------------------------------------------------------------
// byte_pattern_search_wildcard_core
// Streaming byte pattern search with case folding, wildcard and relative
// matching, built as a ring of compare cells.
// ----------------------------------------------------------------------------
// The core takes one item per cycle, either a pattern load or a buffer byte,
// and the result of a byte is registered in the output register, or in the
// skid register behind it while the output register waits; while both
// hold a result, no item is accepted until the receiver takes one. Every cell
// holds one history byte and the pattern byte that lines up with it, so the
// whole window is compared at once. The pattern ring is kept aligned to the
// programmed length; after pattern_length changes, the ring rotates one place
// per cycle until it lines up again, and no item is accepted during that time.
module byte_pattern_search_wildcard_core import bps_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  localparam int OUT_W = ((OFFSET_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // pattern_index [4:0], byte_value [12:5], zero fill above
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tlast,
  // mode
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // offset [OFFSET_BITS-1:0], zero fill above
  output logic [OUT_W-1:0]     m_axis_tdata,
  // found
  output logic                 m_axis_tuser
);

  localparam int AW     = (PATTERN_MAX > 2) ? $clog2(PATTERN_MAX) : 1;
  localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
  localparam int CMP_W  = (LEN_W > 6) ? LEN_W : 6;
  localparam int SW     = ((AW > 5) ? AW : 5) + 1;
  localparam int CNT_W  = OFFSET_BITS + 1;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [CNT_W-1:0] COUNT_MAX = {1'b0, OFFSET_MAX} + CNT_W'(PATTERN_MAX);

  bps_cfg_t cfg;
  bps_ctl_t ctl;

  logic [CMP_W-1:0]       len_ext;
  logic [CMP_W-1:0]       len_eff;
  logic [AW-1:0]          align;
  logic [AW-1:0]          align_target;
  logic                   aligned;
  logic                   in_accept;
  logic                   byte_acc;
  logic                   load_acc;
  logic [4:0]             idx;
  logic [7:0]             val;
  logic                   last;
  logic [SW-1:0]          load_diff;
  logic [AW-1:0]          load_cell;
  logic                   load_ok;

  logic [7:0]             hist [PATTERN_MAX];
  logic [7:0]             pat  [PATTERN_MAX];
  logic [7:0]             win  [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] ok;

  logic [CNT_W-1:0]       cnt;
  logic [CNT_W-1:0]       cnt_next;
  logic [CNT_W-1:0]       off_full;
  logic [OFFSET_BITS-1:0] off;
  logic                   matched;
  logic                   hit;
  logic                   miss;
  logic                   res_v;
  logic [OFFSET_BITS-1:0] res_off;

  logic                   out_valid;
  logic                   out_found;
  logic [OFFSET_BITS-1:0] out_off;
  logic                   skid_valid;
  logic                   skid_found;
  logic [OFFSET_BITS-1:0] skid_off;
  logic                   pop;

  bps_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    len_ext = CMP_W'(cfg.pattern_length);
    if (len_ext == '0) begin
      len_eff = CMP_W'(1);
    end else if (len_ext > CMP_W'(PATTERN_MAX)) begin
      len_eff = CMP_W'(PATTERN_MAX);
    end else begin
      len_eff = len_ext;
    end
  end

  assign align_target = AW'(len_eff - CMP_W'(1));
  assign aligned      = align == align_target;

  assign s_axis_tready = aligned && !skid_valid;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign byte_acc      = in_accept && (s_axis_tuser == MODE_STREAM);
  assign load_acc      = in_accept && (s_axis_tuser == MODE_LOAD);
  assign idx           = s_axis_tdata[4:0];
  assign val           = s_axis_tdata[12:5];
  assign last          = s_axis_tlast;

  always_comb begin
    load_diff = SW'(align) - SW'(idx);
    if (load_diff[SW-1]) begin
      load_diff = load_diff + SW'(PATTERN_MAX);
    end
    load_cell = load_diff[AW-1:0];
    load_ok   = load_acc && (SW'(idx) < SW'(PATTERN_MAX));
  end

  always_comb begin
    ctl.shift           = byte_acc;
    ctl.clear           = byte_acc && last;
    ctl.rotate          = !aligned;
    ctl.case_fold       = cfg.case_fold;
    ctl.relative_mode   = cfg.relative_mode;
    ctl.wildcard_enable = cfg.wildcard_enable;
    ctl.wildcard_char   = cfg.wildcard_char;
    ctl.load_value      = val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      align <= '0;
    end else if (!aligned) begin
      align <= (align == AW'(PATTERN_MAX - 1)) ? '0 : align + AW'(1);
    end
  end

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign win[k] = val;
    end else begin : g_body
      assign win[k] = hist[k-1];
    end

    bps_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctl           (ctl),
      .active        (CMP_W'(k) < len_eff),
      .rel_active    ((k != 0) && (CMP_W'(k) < len_eff)),
      .load          (load_ok && (load_cell == AW'(k))),
      .win_byte      (win[k]),
      .prev_win_byte (win[(k + PATTERN_MAX - 1) % PATTERN_MAX]),
      .pat_in        (pat[(k + PATTERN_MAX - 1) % PATTERN_MAX]),
      .hist          (hist[k]),
      .pat           (pat[k]),
      .ok            (ok[k])
    );
  end

  always_comb begin
    cnt_next = (cnt < COUNT_MAX) ? cnt + CNT_W'(1) : cnt;
    off_full = cnt_next - CNT_W'(len_eff);
    off      = (off_full > {1'b0, OFFSET_MAX}) ? OFFSET_MAX : off_full[OFFSET_BITS-1:0];
    hit      = !matched && (cnt_next >= CNT_W'(len_eff)) && (&ok) &&
               (!cfg.relative_mode || (len_eff >= CMP_W'(2)));
    miss     = last && !matched && !hit;
    res_v    = byte_acc && (hit || miss);
    res_off  = hit ? off : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      matched <= 1'b0;
    end else if (byte_acc) begin
      if (last) begin
        cnt     <= '0;
        matched <= 1'b0;
      end else begin
        cnt     <= cnt_next;
        matched <= matched || hit;
      end
    end
  end

  assign pop = out_valid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_found  <= skid_found;
        out_off    <= skid_off;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || pop) begin
      out_valid <= res_v;
      out_found <= hit;
      out_off   <= res_off;
    end else if (res_v) begin
      skid_valid <= 1'b1;
      skid_found <= hit;
      skid_off   <= res_off;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_found;
  assign m_axis_tdata  = OUT_W'(out_off);

  // The ring never takes an item while it is still rotating into place.
  a_no_accept_rotating: assert property (@(posedge clk) disable iff (rst)
    !aligned |-> !in_accept)
    else $error("item accepted during pattern realignment");

  // The skid stage only fills behind a waiting output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result with an empty output register");

  // A reported match always belongs to a stream that has bytes in it.
  a_matched_count: assert property (@(posedge clk) disable iff (rst)
    matched |-> (cnt != '0))
    else $error("match flag set with an empty byte count");

  // The last byte of a stream leaves the stream state cleared.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (byte_acc && last) |=> (cnt == '0) && !matched)
    else $error("stream state not cleared after last byte");

  // A not-found result carries a zero offset.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("not-found result with nonzero offset");

endmodule

### sv/bps_regs.sv
// ----------------------------------------------------------------------------
// bps_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module bps_regs import bps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output bps_cfg_t          cfg
);

  logic [2:0] index;
  logic       wr;

  assign index  = paddr[4:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_length  <= 6'd1;
      cfg.case_fold       <= 1'b0;
      cfg.relative_mode   <= 1'b0;
      cfg.wildcard_enable <= 1'b0;
      cfg.wildcard_char   <= 8'd0;
    end else if (wr) begin
      unique case (index)
        REG_PATTERN_LENGTH:  cfg.pattern_length  <= pwdata[5:0];
        REG_CASE_FOLD:       cfg.case_fold       <= pwdata[0];
        REG_RELATIVE_MODE:   cfg.relative_mode   <= pwdata[0];
        REG_WILDCARD_ENABLE: cfg.wildcard_enable <= pwdata[0];
        REG_WILDCARD_CHAR:   cfg.wildcard_char   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_PATTERN_LENGTH:  prdata = {26'd0, cfg.pattern_length};
      REG_CASE_FOLD:       prdata = {31'd0, cfg.case_fold};
      REG_RELATIVE_MODE:   prdata = {31'd0, cfg.relative_mode};
      REG_WILDCARD_ENABLE: prdata = {31'd0, cfg.wildcard_enable};
      REG_WILDCARD_CHAR:   prdata = {24'd0, cfg.wildcard_char};
      default:             prdata = '0;
    endcase
  end

endmodule

### sv/bps_cell.sv
// ----------------------------------------------------------------------------
// bps_cell
// One position of the search chain: a history byte, a pattern byte and the
// compare of the two.
// ----------------------------------------------------------------------------
module bps_cell import bps_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  bps_ctl_t   ctl,
  input  logic       active,
  input  logic       rel_active,
  input  logic       load,
  input  logic [7:0] win_byte,
  input  logic [7:0] prev_win_byte,
  input  logic [7:0] pat_in,
  output logic [7:0] hist,
  output logic [7:0] pat,
  output logic       ok
);

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
  endfunction

  logic       wild_skip;
  logic       byte_eq;
  logic [8:0] diff_b;
  logic [8:0] diff_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= 8'd0;
    end else if (ctl.clear) begin
      hist <= 8'd0;
    end else if (ctl.shift) begin
      hist <= win_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pat <= ctl.load_value;
    end else if (ctl.rotate) begin
      pat <= pat_in;
    end
  end

  always_comb begin
    wild_skip = ctl.wildcard_enable && (pat == ctl.wildcard_char);
    if (ctl.case_fold && is_letter(pat)) begin
      byte_eq = fold_lower(win_byte) == fold_lower(pat);
    end else begin
      byte_eq = win_byte == pat;
    end
    diff_b = {1'b0, win_byte} - {1'b0, prev_win_byte};
    diff_p = {1'b0, pat} - {1'b0, pat_in};
    if (ctl.relative_mode) begin
      ok = !rel_active || wild_skip || (diff_b == diff_p);
    end else begin
      ok = !active || wild_skip || byte_eq;
    end
  end

endmodule

### tb/tb_byte_pattern_search_wildcard_core.sv
// ----------------------------------------------------------------------------
// tb_byte_pattern_search_wildcard_core
// Self-checking testbench of the streaming byte pattern search core. Pattern
// loads and buffer bytes go in through the input stream and configuration
// goes in through the register port. An in-bench model of the search
// predicts every found or not-found result, and each result leaving the
// output stream is compared with the oldest prediction. Directed tests cover
// exact, case-folded, wildcard and relative matching and the length limits.
// A long receiver hold-off tests backpressure, and a random part with random
// gaps on both sides follows.
// ----------------------------------------------------------------------------
module tb_byte_pattern_search_wildcard_core;
  timeunit 1ns;
  timeprecision 1ps;
  import bps_pkg::*;

  localparam int PAT_MAX = PATTERN_MAX_DEF;
  localparam int OFF_BITS = OFFSET_BITS_DEF;
  localparam int OUT_W = ((OFF_BITS + 7) / 8) * 8;
  localparam logic [16:0] COUNT_SAT = 17'((1 << OFF_BITS) - 1 + PAT_MAX);
  localparam logic [15:0] OFFSET_SAT = 16'((1 << OFF_BITS) - 1);
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int QUIET_CYCLES = 8;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 1380;
  localparam int MAX_REPORTS = 10;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic        found;
    logic [15:0] offset;
  } search_result_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // pattern_index [4:0], byte_value [12:5], zero fill above
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tlast;
  // mode
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // offset [15:0]
  logic [OUT_W-1:0]     m_axis_tdata;
  // found
  logic                 m_axis_tuser;

  logic [7:0]     pattern_copy [PAT_MAX];
  logic [7:0]     history [PAT_MAX];
  logic [16:0]    stream_count;
  logic           match_seen;
  bps_cfg_t       search_cfg;
  search_result_t expected_results[$];

  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   sent_requests = 0;
  int   tx_gap_max = 19;
  int   rx_gap_max = 19;
  logic long_hold_req = 1'b0;

  byte_pattern_search_wildcard_core DUT (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7, 0))
      0: return 8'h41;
      1: return 8'h61;
      2: return 8'h42;
      3: return 8'h62;
      4: return 8'h00;
      5: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void predict_request(logic mode, logic [4:0] idx, logic [7:0] val,
                                          logic is_last);
    search_result_t res;
    int             len;
    int             off;
    int             db;
    int             dp;
    logic           hit;
    logic [7:0]     p;
    logic [7:0]     b;
    if (mode == MODE_LOAD) begin
      pattern_copy[idx] = val;
      return;
    end
    for (int i = PAT_MAX - 1; i > 0; i--) history[i] = history[i - 1];
    history[0] = val;
    if (stream_count < COUNT_SAT) stream_count = stream_count + 1'b1;
    len = (search_cfg.pattern_length == 0) ? 1 :
          (search_cfg.pattern_length > PAT_MAX) ? PAT_MAX : int'(search_cfg.pattern_length);
    hit = (stream_count >= len) && !(search_cfg.relative_mode && len < 2);
    for (int i = 0; i < len && hit; i++) begin
      p = pattern_copy[i];
      b = history[len - 1 - i];
      if (search_cfg.wildcard_enable && p == search_cfg.wildcard_char) continue;
      if (search_cfg.relative_mode) begin
        if (i + 1 < len) begin
          db = int'(b) - int'(history[len - 2 - i]);
          dp = int'(p) - int'(pattern_copy[i + 1]);
          hit = (db == dp);
        end
      end else if (search_cfg.case_fold && is_alpha(p)) begin
        hit = (to_lower(b) == to_lower(p));
      end else begin
        hit = (b == p);
      end
    end
    if (!match_seen && hit) begin
      off = int'(stream_count) - len;
      res.found = 1'b1;
      res.offset = (off > int'(OFFSET_SAT)) ? OFFSET_SAT : 16'(off);
      expected_results.push_back(res);
      match_seen = 1'b1;
    end else if (is_last && !match_seen) begin
      res.found = 1'b0;
      res.offset = '0;
      expected_results.push_back(res);
    end
    if (is_last) begin
      foreach (history[i]) history[i] = '0;
      stream_count = '0;
      match_seen = 1'b0;
    end
  endfunction

  task automatic send_request(logic mode, logic [4:0] idx, logic [7:0] val, logic is_last);
    int gap;
    gap = (tx_gap_max > 0) ? $urandom_range(tx_gap_max, 0) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tlast <= is_last;
    s_axis_tdata <= {3'b000, val, idx};
    do @(posedge clk); while (!s_axis_tready);
    predict_request(mode, idx, val, is_last);
    sent_requests++;
  endtask

  task automatic load_pattern(byte_q_t pat);
    foreach (pat[i]) send_request(MODE_LOAD, 5'(i), pat[i], 1'b0);
  endtask

  task automatic send_stream(byte_q_t data);
    foreach (data[i])
      send_request(MODE_STREAM, 5'($urandom), data[i], i == data.size() - 1);
  endtask

  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] reg_index, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_index, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (reg_index)
      REG_PATTERN_LENGTH:  search_cfg.pattern_length = value[5:0];
      REG_CASE_FOLD:       search_cfg.case_fold = value[0];
      REG_RELATIVE_MODE:   search_cfg.relative_mode = value[0];
      REG_WILDCARD_ENABLE: search_cfg.wildcard_enable = value[0];
      REG_WILDCARD_CHAR:   search_cfg.wildcard_char = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_search_mode(logic [5:0] len, logic fold, logic rel, logic wild,
                                 logic [7:0] wchar);
    settle();
    write_register(REG_PATTERN_LENGTH, 32'(len));
    write_register(REG_CASE_FOLD, 32'(fold));
    write_register(REG_RELATIVE_MODE, 32'(rel));
    write_register(REG_WILDCARD_ENABLE, 32'(wild));
    write_register(REG_WILDCARD_CHAR, 32'(wchar));
  endtask

  task automatic test_pattern_load();
    for (int i = 0; i < PAT_MAX; i++)
      send_request(MODE_LOAD, 5'(i),
                   (i == 0) ? 8'h00 : (i == PAT_MAX - 1) ? 8'hff : 8'($urandom),
                   1'(i % 2));
  endtask

  task automatic test_exact_match();
    set_search_mode(6'd3, 1'b0, 1'b0, 1'b0, 8'h00);
    load_pattern({8'h00, 8'hff, 8'h41});
    send_stream({8'h00, 8'hff, 8'h41, 8'h12, 8'h00, 8'hff, 8'h41});
    send_stream({8'h41, 8'hff, 8'h00});
    send_stream({8'h10, 8'h00, 8'hff, 8'h41});
  endtask

  task automatic test_case_fold();
    set_search_mode(6'd4, 1'b1, 1'b0, 1'b0, 8'h00);
    load_pattern({8'h61, 8'h5a, 8'h40, 8'h5b});
    send_stream({8'h41, 8'h7a, 8'h40, 8'h5b});
    send_stream({8'h41, 8'h7a, 8'h60, 8'h7b});
    set_search_mode(6'd4, 1'b0, 1'b0, 1'b0, 8'h00);
    send_stream({8'h41, 8'h7a, 8'h40, 8'h5b});
  endtask

  task automatic test_wildcard();
    set_search_mode(6'd3, 1'b0, 1'b0, 1'b1, 8'h3f);
    load_pattern({8'h61, 8'h3f, 8'h63});
    send_stream({8'h00, 8'h61, 8'hff, 8'h63});
    set_search_mode(6'd3, 1'b1, 1'b0, 1'b1, 8'hff);
    load_pattern({8'h41, 8'hff, 8'hff});
    send_stream({8'h61, 8'h00, 8'h7e});
  endtask

  task automatic test_relative();
    set_search_mode(6'd3, 1'b1, 1'b1, 1'b0, 8'h00);
    load_pattern({8'h0a, 8'h14, 8'h0f});
    send_stream({8'h64, 8'h6e, 8'h69});
    set_search_mode(6'd3, 1'b0, 1'b1, 1'b1, 8'h0a);
    send_stream({8'h00, 8'h50, 8'h4b});
    set_search_mode(6'd1, 1'b0, 1'b1, 1'b0, 8'h00);
    send_stream({8'h0a, 8'h0a, 8'h0a});
    set_search_mode(6'd2, 1'b0, 1'b1, 1'b0, 8'h00);
    load_pattern({8'h00, 8'hff});
    send_stream({8'h00, 8'hff});
    send_stream({8'h01, 8'h00});
  endtask

  task automatic test_length_extremes();
    byte_q_t pat;
    byte_q_t data;
    set_search_mode(6'd0, 1'b0, 1'b0, 1'b0, 8'h00);
    load_pattern({8'h5a});
    send_stream({8'h01, 8'h5a, 8'h5a});
    repeat (PAT_MAX) pat.push_back(pick_byte());
    set_search_mode(6'(PAT_MAX), 1'b0, 1'b0, 1'b0, 8'h00);
    load_pattern(pat);
    data = {8'($urandom), 8'($urandom), 8'($urandom)};
    foreach (pat[i]) data.push_back(pat[i]);
    send_stream(data);
    set_search_mode(6'(PAT_MAX + 1), 1'b0, 1'b0, 1'b0, 8'h00);
    send_stream(pat);
    set_search_mode(6'd63, 1'b0, 1'b0, 1'b0, 8'h00);
    void'(pat.pop_back());
    send_stream(pat);
  endtask

  task automatic test_backpressure();
    set_search_mode(6'd1, 1'b0, 1'b0, 1'b0, 8'h00);
    load_pattern({8'h5a});
    tx_gap_max = 0;
    long_hold_req = 1'b1;
    repeat (40)
      send_request(MODE_STREAM, 5'($urandom),
                   $urandom_range(1, 0) ? 8'h5a : 8'($urandom), 1'b1);
    tx_gap_max = 19;
  endtask

  task automatic test_random();
    int         start;
    int         len_code;
    int         eff;
    logic       fold;
    logic       rel;
    logic       wild;
    logic [7:0] wchar;
    logic [7:0] shift;
    logic [7:0] b;
    byte_q_t    pat;
    byte_q_t    data;
    start = sent_requests;
    while (sent_requests - start < RANDOM_ITEMS) begin
      tx_gap_max = $urandom_range(1, 0) ? 19 : 0;
      rx_gap_max = $urandom_range(1, 0) ? 19 : 0;
      case ($urandom_range(9, 0))
        0: len_code = 0;
        1: len_code = PAT_MAX;
        2: len_code = $urandom_range(63, PAT_MAX + 1);
        default: len_code = $urandom_range(8, 1);
      endcase
      eff = (len_code == 0) ? 1 : (len_code > PAT_MAX) ? PAT_MAX : len_code;
      fold = 1'($urandom);
      rel = ($urandom_range(3, 0) == 0);
      wild = 1'($urandom);
      pat = {};
      repeat (eff) pat.push_back(pick_byte());
      wchar = $urandom_range(1, 0) ? pat[$urandom_range(eff - 1, 0)] : pick_byte();
      set_search_mode(6'(len_code), fold, rel, wild, wchar);
      load_pattern(pat);
      repeat ($urandom_range(4, 1)) begin
        data = {};
        repeat ($urandom_range(6, 0)) data.push_back(pick_byte());
        if ($urandom_range(3, 0) != 0) begin
          shift = $urandom_range(1, 0) ? 8'($urandom_range(8, 1)) : 8'($urandom);
          for (int i = 0; i < eff; i++) begin
            b = pat[i];
            if (rel) b = b + shift;
            else if (wild && b == wchar) b = pick_byte();
            else if (fold && is_alpha(b) && $urandom_range(1, 0)) b = b ^ 8'h20;
            data.push_back(b);
          end
        end
        repeat ($urandom_range(4, 0)) data.push_back(pick_byte());
        if (data.size() == 0) data.push_back(pick_byte());
        foreach (data[i]) begin
          if ($urandom_range(15, 0) == 0)
            send_request(MODE_LOAD, 5'($urandom_range(eff - 1, 0)), pick_byte(),
                         1'($urandom));
          send_request(MODE_STREAM, 5'($urandom), data[i], i == data.size() - 1);
        end
      end
    end
  endtask

  initial begin : result_sink
    int rx_wait;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold_req = 1'b0;
      end else begin
        rx_wait = (rx_gap_max > 0) ? $urandom_range(rx_gap_max, 0) : 0;
        if (rx_wait > 0) begin
          m_axis_tready <= 1'b0;
          repeat (rx_wait) @(negedge clk);
        end
        m_axis_tready <= 1'b1;
        do @(posedge clk); while (!m_axis_tvalid && !long_hold_req);
      end
    end
  end

  always @(posedge clk) begin : check_results
    search_result_t seen;
    search_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.found = m_axis_tuser;
      seen.offset = m_axis_tdata[15:0];
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: found=%0b offset=%0d", seen.found, seen.offset);
      end else begin
        want = expected_results.pop_front();
        if (seen.found !== want.found || seen.offset !== want.offset) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result mismatch: expected found=%0b offset=%0d, got found=%0b offset=%0d",
                     want.found, want.offset, seen.found, seen.offset);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    s_axis_tuser = MODE_LOAD;
    search_cfg = '{pattern_length: 6'd1, wildcard_char: 8'h00, default: 1'b0};
    foreach (history[i]) history[i] = '0;
    foreach (pattern_copy[i]) pattern_copy[i] = '0;
    stream_count = '0;
    match_seen = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    test_pattern_load();
    test_exact_match();
    test_case_fold();
    test_wildcard();
    test_relative();
    test_length_extremes();
    test_backpressure();
    test_random();
    settle();

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
